// ===== rtl/smmn_pkg.sv =====
// Package: shared constants for the sliding min/max normaliser.
package smmn_pkg;
    localparam int MaxWindow  = 2048;
    localparam int SampleBits = 10;
    localparam int PtrBits    = $clog2(MaxWindow);
    localparam int LenBits    = 12;
    localparam int AgeBits    = 12;
    localparam logic [SampleBits-1:0] SampleMax = {SampleBits{1'b1}};
    localparam logic [SampleBits-1:0] MinSpan   = SampleBits'(10);
    localparam logic [7:0]            ScaleMax  = 8'd255;
    localparam logic [AgeBits-1:0]    AgeMax    = {AgeBits{1'b1}};
    localparam logic [0:0] RegWindowLength = 1'b0;
    localparam logic [0:0] RegDropBits     = 1'b1;
endpackage

// ===== rtl/sliding_minmax_normalizer_core.sv =====
// Top level: sliding-window min/max tracker and 8-bit rescaler.
//
//  channel | direction | tdata fields (low bit up)          | tuser
//  s_      | in        | sample[9:0]                         | frame_start
//  m_      | out       | scaled_value[7:0], window_min[17:8], window_max[27:18] | -
//  cfg     | in        | wr_en, wr_index (0 window_length, 1 drop_bits), wr_data[11:0]
//
// One word at a time: a word passes through the store, the age check, any rescans and
// the bit-serial divider before its result word is formed.
// A window scan streams one memory entry per cycle through the single read port;
// a frame start costs two scans, an aged-out extreme one each.
// After reset the store is cleared one entry a cycle, every entry, with s_tready
// low. The result word is held; the next word is taken only once it has been delivered.
module sliding_minmax_normalizer_core
    import smmn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[9:0], zero fill
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // scaled_value[7:0], window_min[17:8], window_max[27:18]
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [11:0] wr_data
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_WRITE, ST_CHECK, ST_DIV_SETUP, ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SK_FRAME_MIN, SK_FRAME_MAX, SK_AGE_MIN, SK_AGE_MAX
    } scan_kind_t;

    // window store, one write and one registered read port
    logic [SampleBits-1:0] mem [MaxWindow];
    logic                  mem_we;
    logic [PtrBits-1:0]    mem_waddr, mem_raddr;
    logic [SampleBits-1:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    state_t state_reg;
    logic [LenBits-1:0]    len_cfg_reg;
    logic [2:0]            drop_reg;
    logic [PtrBits-1:0]    wp_reg;
    logic [SampleBits-1:0] min_reg, max_reg, samp_reg;
    logic [AgeBits-1:0]    min_age_reg, max_age_reg;
    // scan control
    logic                  scan_min_reg;   // scanning for minimum
    scan_kind_t            scan_kind_reg;  // which extreme and why
    logic [PtrBits:0]      scan_k_reg;     // issued remaining count
    logic [PtrBits:0]      scan_kd_reg;    // age of data arriving
    logic                  scan_dv_reg;
    logic [PtrBits-1:0]    scan_last_reg;
    logic [SampleBits-1:0] best_reg;
    logic [AgeBits-1:0]    best_age_reg;
    logic                  need_max_reg;
    // divider
    logic [18:0]           rem_reg;
    logic [19:0]           dvs_reg;
    logic [8:0]            quo_reg;
    logic [3:0]            dcnt_reg;
    logic [PtrBits:0]      clr_reg;

    logic [PtrBits:0] len_eff;
    always_comb begin
        if (len_cfg_reg < LenBits'(4)) begin
            len_eff = (PtrBits+1)'(4);
        end else if (len_cfg_reg > LenBits'(MaxWindow)) begin
            len_eff = (PtrBits+1)'(MaxWindow);
        end else begin
            len_eff = len_cfg_reg[PtrBits:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;

    logic [PtrBits-1:0] prev_ptr;
    assign prev_ptr = wp_reg - PtrBits'(1);

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg;
        mem_wdata = samp_reg;
        mem_raddr = scan_last_reg - PtrBits'(scan_k_reg - (PtrBits+1)'(1));
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[PtrBits-1:0];
            mem_wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            mem_we = 1'b1;
        end
    end

    logic better;
    assign better = scan_min_reg ? (mem_rdata_reg < best_reg) : (mem_rdata_reg > best_reg);

    logic [AgeBits-1:0] min_age_inc, max_age_inc;
    assign min_age_inc = (min_age_reg == AgeMax) ? AgeMax : min_age_reg + AgeBits'(1);
    assign max_age_inc = (max_age_reg == AgeMax) ? AgeMax : max_age_reg + AgeBits'(1);

    logic [SampleBits-1:0] span;
    always_comb begin
        span = max_reg - min_reg;
        if (max_reg <= min_reg || span < MinSpan) begin
            span = MinSpan;
        end
    end

    // one guard bit beyond the divisor so a large divisor never wraps into a fit
    logic [20:0] trial;
    assign trial = {2'b00, rem_reg} - {1'b0, dvs_reg};
    logic [8:0] quo_sat;
    assign quo_sat = (quo_reg > 9'(ScaleMax)) ? 9'(ScaleMax) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wp_reg      <= '0;
            min_reg     <= SampleMax;
            max_reg     <= '0;
            min_age_reg <= '0;
            max_age_reg <= '0;
            len_cfg_reg <= LenBits'(1024);
            drop_reg    <= '0;
            m_tvalid    <= 1'b0;
            scan_dv_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                case (wr_index)
                    RegWindowLength: len_cfg_reg <= wr_data;
                    RegDropBits:     drop_reg    <= wr_data[2:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + (PtrBits+1)'(1);
                    if (clr_reg == (PtrBits+1)'(MaxWindow - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        samp_reg <= s_tdata[SampleBits-1:0];
                        if (s_tuser) begin
                            scan_min_reg  <= 1'b1;
                            scan_kind_reg <= SK_FRAME_MIN;
                            scan_last_reg <= prev_ptr;
                            scan_k_reg    <= len_eff;
                            scan_dv_reg   <= 1'b0;
                            best_reg      <= SampleMax;
                            best_age_reg  <= '0;
                            state_reg     <= ST_SCAN;
                        end else begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue one read, fold in the previous one
                    if (scan_k_reg != '0) begin
                        scan_k_reg  <= scan_k_reg - (PtrBits+1)'(1);
                        scan_kd_reg <= scan_k_reg - (PtrBits+1)'(1);
                        scan_dv_reg <= 1'b1;
                    end else begin
                        scan_dv_reg <= 1'b0;
                    end
                    if (scan_dv_reg && better && scan_k_reg != '0) begin
                        best_reg     <= mem_rdata_reg;
                        best_age_reg <= AgeBits'(scan_kd_reg);
                    end
                    if (scan_k_reg == '0 && scan_dv_reg) begin
                        // scan done: commit result
                        if (scan_min_reg) begin
                            min_reg     <= (better) ? mem_rdata_reg : best_reg;
                            min_age_reg <= (better) ? AgeBits'(scan_kd_reg) : best_age_reg;
                        end else begin
                            max_reg     <= (better) ? mem_rdata_reg : best_reg;
                            max_age_reg <= (better) ? AgeBits'(scan_kd_reg) : best_age_reg;
                        end
                        case (scan_kind_reg)
                            SK_FRAME_MIN: begin
                                scan_min_reg  <= 1'b0;
                                scan_kind_reg <= SK_FRAME_MAX;
                                scan_k_reg    <= len_eff;
                                best_reg      <= '0;
                                best_age_reg  <= '0;
                            end
                            SK_FRAME_MAX: state_reg <= ST_WRITE;
                            SK_AGE_MIN: begin
                                if (need_max_reg) begin
                                    scan_min_reg  <= 1'b0;
                                    scan_kind_reg <= SK_AGE_MAX;
                                    scan_k_reg    <= len_eff;
                                    best_reg      <= '0;
                                    best_age_reg  <= '0;
                                end else begin
                                    state_reg <= ST_DIV_SETUP;
                                end
                            end
                            default: state_reg <= ST_DIV_SETUP;
                        endcase
                    end
                end
                ST_WRITE: begin
                    // store the word and age both extremes
                    wp_reg <= wp_reg + PtrBits'(1);
                    scan_last_reg <= wp_reg;
                    if (samp_reg < min_reg) begin
                        min_reg <= samp_reg;
                        min_age_reg <= '0;
                    end else begin
                        min_age_reg <= min_age_inc;
                    end
                    if (samp_reg > max_reg) begin
                        max_reg <= samp_reg;
                        max_age_reg <= '0;
                    end else begin
                        max_age_reg <= max_age_inc;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    need_max_reg <= (max_age_reg >= AgeBits'(len_eff));
                    scan_k_reg   <= len_eff;
                    scan_dv_reg  <= 1'b0;
                    best_age_reg <= '0;
                    if (min_age_reg >= AgeBits'(len_eff)) begin
                        scan_min_reg  <= 1'b1;
                        scan_kind_reg <= SK_AGE_MIN;
                        best_reg      <= SampleMax;
                        state_reg     <= ST_SCAN;
                    end else if (max_age_reg >= AgeBits'(len_eff)) begin
                        scan_min_reg  <= 1'b0;
                        scan_kind_reg <= SK_AGE_MAX;
                        best_reg      <= '0;
                        state_reg     <= ST_SCAN;
                    end else begin
                        state_reg <= ST_DIV_SETUP;
                    end
                end
                ST_DIV_SETUP: begin
                    // numerator 510*d + span, divisor 2*span
                    rem_reg  <= 19'(samp_reg - min_reg) * 19'd510 + 19'(span);
                    dvs_reg  <= {9'd0, span, 1'b0} << 9;
                    quo_reg  <= '0;
                    dcnt_reg <= 4'd9;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[20]) begin
                        rem_reg <= trial[18:0];
                    end
                    quo_reg  <= {quo_reg[7:0], !trial[20]};
                    dvs_reg  <= dvs_reg >> 1;
                    dcnt_reg <= dcnt_reg - 4'd1;
                    if (dcnt_reg == 4'd0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    m_tdata   <= {4'd0, max_reg, min_reg, quo_sat[7:0] >> drop_reg};
                    m_tvalid  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/smmn_checker.sv =====
// Checker: port-level properties of the normaliser, bound to the top level.
module smmn_checker
    import smmn_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output moved");
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_minmax: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:8] <= m_tdata[27:18]) else $error("min above max");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind sliding_minmax_normalizer_core smmn_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
